/* sv/tga_rle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_pkg
// shared types and constants of the targa run-length pixel decoder
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  localparam int unsigned DefaultMaxUnitBytes = 4;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PixelW   = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned UnitsW   = 32;
  localparam int unsigned UnitSzW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [ByteW-1:0] RunFlagMask = 8'h80;
  localparam logic [ByteW-1:0] RunLenMask  = 8'h7f;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BYTES_PER_UNIT = 2'd0,
    CFG_RLE_ENABLED    = 2'd1,
    CFG_TOTAL_UNITS    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [UnitSzW-1:0] bytes_per_unit;
    logic               rle_enabled;
    logic [UnitsW-1:0]  total_units;
  } cfg_t;

  typedef struct packed {
    logic              run_clipped;
    logic              last_of_image;
    logic [CountW-1:0] repeat_count;
    logic [PixelW-1:0] pixel_value;
  } result_t;

endpackage
`default_nettype wire

/* sv/tga_rle_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_core
// decoder state and one-byte step: header parse, unit assembly, run clipping
// ----------------------------------------------------------------------------
module tga_rle_core #(
  parameter int unsigned MAX_UNIT_BYTES = tga_rle_pkg::DefaultMaxUnitBytes
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire tga_rle_pkg::cfg_t              cfg_i,
  input  wire logic                           step_i,
  input  wire logic [tga_rle_pkg::ByteW-1:0]  byte_i,
  output tga_rle_pkg::result_t                res_o,
  output logic                                res_vld_o
);

  localparam logic [tga_rle_pkg::UnitSzW-1:0] MaxUnit =
    tga_rle_pkg::UnitSzW'(MAX_UNIT_BYTES);

  logic                                  awaiting_q, awaiting_d;
  logic [1:0]                            pos_q, pos_d;
  logic [tga_rle_pkg::PixelW-1:0]        asm_q, asm_d;
  logic [tga_rle_pkg::CountW-1:0]        rem_q, rem_d;
  logic                                  rpt_q, rpt_d;
  logic [tga_rle_pkg::UnitsW-1:0]        written_q, written_d;

  logic [tga_rle_pkg::UnitSzW-1:0]       unit_n;
  logic [tga_rle_pkg::UnitsW-1:0]        tot, left;
  logic [tga_rle_pkg::PixelW-1:0]        asm_new, mask;
  logic [tga_rle_pkg::CountW-1:0]        cnt, rem_eff, rem_dec;
  logic                                  more, over, done, emit;

  always_comb begin
    if (cfg_i.bytes_per_unit == '0) begin
      unit_n = tga_rle_pkg::UnitSzW'(1);
    end else if (cfg_i.bytes_per_unit > MaxUnit) begin
      unit_n = MaxUnit;
    end else begin
      unit_n = cfg_i.bytes_per_unit;
    end
  end

  always_comb begin
    case (unit_n)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign tot  = (cfg_i.total_units == '0) ? tga_rle_pkg::UnitsW'(1) : cfg_i.total_units;
  assign left = (written_q < tot) ? (tot - written_q) : tga_rle_pkg::UnitsW'(1);

  assign asm_new = asm_q | (tga_rle_pkg::PixelW'(byte_i) << {pos_q, 3'b000});
  assign rem_eff = (rem_q == '0) ? tga_rle_pkg::CountW'(1) : rem_q;
  assign rem_dec = rem_eff - tga_rle_pkg::CountW'(1);

  always_comb begin
    if (!cfg_i.rle_enabled) begin
      cnt  = tga_rle_pkg::CountW'(1);
      more = 1'b0;
    end else if (rpt_q) begin
      cnt  = rem_eff;
      more = 1'b0;
    end else begin
      cnt  = tga_rle_pkg::CountW'(1);
      more = (rem_dec != '0);
    end
  end

  assign over = (tga_rle_pkg::UnitsW'(cnt) > left);
  assign done = over || (tga_rle_pkg::UnitsW'(cnt) == left);

  always_comb begin
    awaiting_d = awaiting_q;
    pos_d      = pos_q;
    asm_d      = asm_q;
    rem_d      = rem_q;
    rpt_d      = rpt_q;
    written_d  = written_q;
    emit       = 1'b0;
    if (step_i) begin
      if (cfg_i.rle_enabled && awaiting_q) begin
        rpt_d      = (byte_i & tga_rle_pkg::RunFlagMask) != '0;
        rem_d      = (byte_i & tga_rle_pkg::RunLenMask) + tga_rle_pkg::CountW'(1);
        awaiting_d = 1'b0;
        pos_d      = '0;
        asm_d      = '0;
      end else if (({1'b0, pos_q} + 3'd1) < unit_n) begin
        asm_d = asm_new;
        pos_d = pos_q + 2'd1;
      end else begin
        emit  = 1'b1;
        asm_d = '0;
        pos_d = '0;
        if (cfg_i.rle_enabled) begin
          if (rpt_q) begin
            rem_d      = '0;
            awaiting_d = 1'b1;
          end else begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              awaiting_d = 1'b1;
            end
          end
        end
        if (done) begin
          written_d  = '0;
          awaiting_d = 1'b1;
          rem_d      = '0;
          rpt_d      = 1'b0;
        end else begin
          written_d = written_q + tga_rle_pkg::UnitsW'(cnt);
        end
      end
    end
  end

  always_comb begin
    res_vld_o           = emit;
    res_o.pixel_value   = asm_new & mask;
    res_o.repeat_count  = over ? left[tga_rle_pkg::CountW-1:0] : cnt;
    res_o.last_of_image = done;
    res_o.run_clipped   = over || (done && more);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b1;
      pos_q      <= '0;
      asm_q      <= '0;
      rem_q      <= '0;
      rpt_q      <= 1'b0;
      written_q  <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      pos_q      <= pos_d;
      asm_q      <= asm_d;
      rem_q      <= rem_d;
      rpt_q      <= rpt_d;
      written_q  <= written_d;
    end
  end

endmodule
`default_nettype wire

/* sv/tga_rle_pixel_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// an accepted byte passes the input register, then the decoder step and the output register
// throughput: one payload byte per cycle while the output is not stalled, results held in an output register
// the input register frees whenever the output register is empty or taken
// reset: asynchronous, active low; configuration returns to 4-byte units,
// run-length coding on and a one-unit image, decoder awaits a packet header
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// targa pixel payload decoder, one byte in, pixel unit and repeat count out
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit #(
  parameter int unsigned MAX_UNIT_BYTES = tga_rle_pkg::DefaultMaxUnitBytes
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [tga_rle_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [tga_rle_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [7:0]                          s_axis_tdata,  // data_byte
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [39:0]                              m_axis_tdata,  // pixel_value, repeat_count
  output logic                                     m_axis_tlast,  // last_of_image
  output logic                                     m_axis_tuser   // run_clipped
);

  tga_rle_pkg::cfg_t    cfg_q, cfg_d;
  tga_rle_pkg::result_t res, out_q;
  logic                 res_vld;
  logic                 in_vld_q, in_vld_d;
  logic [7:0]           in_byte_q;
  logic                 out_vld_q, out_vld_d;
  logic                 out_free, advance, in_take;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (tga_rle_pkg::cfg_idx_e'(cfg_index_i))
        tga_rle_pkg::CFG_BYTES_PER_UNIT:
          cfg_d.bytes_per_unit = cfg_wdata_i[tga_rle_pkg::UnitSzW-1:0];
        tga_rle_pkg::CFG_RLE_ENABLED:
          cfg_d.rle_enabled = cfg_wdata_i[0];
        tga_rle_pkg::CFG_TOTAL_UNITS:
          cfg_d.total_units = cfg_wdata_i[tga_rle_pkg::UnitsW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  assign in_vld_d  = in_take || (in_vld_q && !advance);
  assign out_vld_d = out_free ? (advance && res_vld) : out_vld_q;

  tga_rle_core #(
    .MAX_UNIT_BYTES (MAX_UNIT_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .res_o     (res),
    .res_vld_o (res_vld)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_unit <= tga_rle_pkg::UnitSzW'(4);
      cfg_q.rle_enabled    <= 1'b1;
      cfg_q.total_units    <= tga_rle_pkg::UnitsW'(1);
      in_vld_q             <= 1'b0;
      out_vld_q            <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (out_free && advance && res_vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.repeat_count, out_q.pixel_value};
  assign m_axis_tlast  = out_q.last_of_image;
  assign m_axis_tuser  = out_q.run_clipped;

endmodule
`default_nettype wire

/* dv/tb_tga_rle_pixel_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder_unit
// Self-checking bench for the targa payload decoder. A directed table covers
// the reset state, the extremes of unit size and image size, clipped runs and
// changes of configuration in the middle of an image or a unit. Random phases
// then follow, each with a fresh setting, mostly well-formed packets with
// random content plus noise and truncated packets. Every accepted byte goes
// through a local decoder model; output words are compared in order.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder_unit;

  localparam int unsigned RandomBytes = 1350;
  localparam int unsigned DrainLimit  = 5000;

  typedef struct {
    bit                                  is_reg;
    tga_rle_pkg::cfg_idx_e               idx;
    logic [tga_rle_pkg::CfgDataW-1:0]    val;
    bit                                  typed;
    tga_rle_pkg::result_t                res;
  } stim_row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [tga_rle_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [tga_rle_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata;   // data_byte
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [39:0]                      m_axis_tdata;   // pixel_value, repeat_count
  logic                             m_axis_tlast;   // last_of_image
  logic                             m_axis_tuser;   // run_clipped

  // decoder model state
  logic [tga_rle_pkg::UnitSzW-1:0]  cfg_bpu;
  logic                             cfg_rle;
  logic [tga_rle_pkg::UnitsW-1:0]   cfg_total;
  logic                             hdr_wait;
  logic [1:0]                       byte_pos;
  logic [tga_rle_pkg::PixelW-1:0]   unit_acc;
  logic [7:0]                       pkt_left;
  logic                             pkt_rep;
  logic [tga_rle_pkg::UnitsW-1:0]   units_done;

  tga_rle_pkg::result_t pixel_q[$];
  stim_row_t            stim_rows[$];
  int unsigned          errors;
  int unsigned          sent;
  bit                   calm;
  bit                   hold_req;
  int unsigned          hold_left;

  tga_rle_pixel_decoder_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #5_000_000;
    $display("tb_tga_rle_pixel_decoder_unit failed");
    $finish;
  end

  function automatic int unsigned MAX_UNIT_BYTES_TB();
    return tga_rle_pkg::DefaultMaxUnitBytes;
  endfunction

  function automatic int unsigned unit_bytes();
    if (cfg_bpu == 0) return 1;
    if (cfg_bpu > MAX_UNIT_BYTES_TB()) return MAX_UNIT_BYTES_TB();
    return cfg_bpu;
  endfunction

  function automatic tga_rle_pkg::result_t finish_unit(
      input logic [tga_rle_pkg::PixelW-1:0] value,
      input int unsigned cnt, input bit more);
    tga_rle_pkg::result_t r;
    int unsigned          tot;
    int unsigned          left;
    tot  = (cfg_total != 0) ? cfg_total : 1;
    left = (units_done < tot) ? tot - units_done : 1;
    r = '0;
    if (cnt > left) begin
      cnt = left;
      r.run_clipped = 1'b1;
    end
    if (cnt == left) begin
      r.last_of_image = 1'b1;
      if (more) r.run_clipped = 1'b1;
      units_done = '0;
      hdr_wait   = 1'b1;
      pkt_left   = '0;
      pkt_rep    = 1'b0;
    end else begin
      units_done = units_done + cnt;
    end
    r.pixel_value  = value;
    r.repeat_count = 8'(cnt);
    return r;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, output bit got,
                                      output tga_rle_pkg::result_t r);
    int unsigned                    n;
    int unsigned                    rem;
    logic [tga_rle_pkg::PixelW-1:0] value;
    got = 1'b0;
    r   = '0;
    n   = unit_bytes();
    if (cfg_rle && hdr_wait) begin
      pkt_rep  = (b & tga_rle_pkg::RunFlagMask) != 0;
      pkt_left = {1'b0, b[6:0]} + 8'd1;
      hdr_wait = 1'b0;
      byte_pos = '0;
      unit_acc = '0;
      return;
    end
    unit_acc = unit_acc | (32'(b) << (8 * byte_pos));
    if (byte_pos + 1 < n) begin
      byte_pos = byte_pos + 2'd1;
      return;
    end
    value    = (n >= 4) ? unit_acc : unit_acc & ((32'd1 << (8 * n)) - 32'd1);
    byte_pos = '0;
    unit_acc = '0;
    got      = 1'b1;
    if (!cfg_rle) begin
      r = finish_unit(value, 1, 1'b0);
    end else if (pkt_rep) begin
      rem      = (pkt_left != 0) ? pkt_left : 1;
      pkt_left = '0;
      hdr_wait = 1'b1;
      r = finish_unit(value, rem, 1'b0);
    end else begin
      rem      = ((pkt_left != 0) ? pkt_left : 1) - 1;
      pkt_left = 8'(rem);
      if (rem == 0) hdr_wait = 1'b1;
      r = finish_unit(value, 1, rem != 0);
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    stim_row_t row;
    row = '{is_reg: 1'b0, idx: tga_rle_pkg::CFG_BYTES_PER_UNIT, val: 32'(b),
            typed: 1'b0, res: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_word(input logic [7:0] b,
                                   input logic [tga_rle_pkg::PixelW-1:0] pix,
                                   input logic [tga_rle_pkg::CountW-1:0] cnt,
                                   input bit last, input bit clip);
    stim_row_t row;
    row = '{is_reg: 1'b0, idx: tga_rle_pkg::CFG_BYTES_PER_UNIT, val: 32'(b),
            typed: 1'b1,
            res: '{run_clipped: clip, last_of_image: last, repeat_count: cnt,
                   pixel_value: pix}};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_reg(input tga_rle_pkg::cfg_idx_e idx,
                                  input logic [tga_rle_pkg::CfgDataW-1:0] val);
    stim_row_t row;
    row = '{is_reg: 1'b1, idx: idx, val: val, typed: 1'b0, res: '0};
    stim_rows.push_back(row);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input tga_rle_pkg::result_t typed_res);
    bit                   got;
    tga_rle_pkg::result_t r;
    calm = (sent >= 700) && (sent < 950);
    if (!calm && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 23);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, got, r);
    if (got) pixel_q.push_back(typed ? typed_res : r);
    sent++;
  endtask

  // wait for every expected word, then for the pipeline to empty
  task automatic settle_decoder();
    int unsigned waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pixel_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pixel_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived, next %h", $time,
               pixel_q.size(), pixel_q[0]);
      errors++;
      pixel_q.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input tga_rle_pkg::cfg_idx_e idx,
                           input logic [tga_rle_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      tga_rle_pkg::CFG_BYTES_PER_UNIT: cfg_bpu   = val[tga_rle_pkg::UnitSzW-1:0];
      tga_rle_pkg::CFG_RLE_ENABLED:    cfg_rle   = val[0];
      tga_rle_pkg::CFG_TOTAL_UNITS:    cfg_total = val;
      default: ;
    endcase
  endtask

  function automatic logic [tga_rle_pkg::CfgDataW-1:0] rand_total();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'hfffe_0001;
      2: return 32'hffff_ffff;
      3: return 32'd1;
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  // receiver, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req      <= 1'b0;
      hold_left     <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk_i) begin : check_words
    tga_rle_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h last %b clip %b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (want.pixel_value !== m_axis_tdata[31:0]) begin
          $display("%0t: pixel_value expected %h actual %h", $time,
                   want.pixel_value, m_axis_tdata[31:0]);
          errors++;
        end
        if (want.repeat_count !== m_axis_tdata[39:32]) begin
          $display("%0t: repeat_count expected %0d actual %0d", $time,
                   want.repeat_count, m_axis_tdata[39:32]);
          errors++;
        end
        if (want.last_of_image !== m_axis_tlast) begin
          $display("%0t: last_of_image expected %b actual %b", $time,
                   want.last_of_image, m_axis_tlast);
          errors++;
        end
        if (want.run_clipped !== m_axis_tuser) begin
          $display("%0t: run_clipped expected %b actual %b", $time,
                   want.run_clipped, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned n;
    int unsigned len;
    int unsigned units;
    int unsigned kind;
    bit          hold_done;
    bit          wrote;
    stim_row_t   row;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    errors        = 0;
    sent          = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    hold_done     = 1'b0;

    cfg_bpu    = 3'd4;
    cfg_rle    = 1'b1;
    cfg_total  = 32'd1;
    hdr_wait   = 1'b1;
    byte_pos   = '0;
    unit_acc   = '0;
    pkt_left   = '0;
    pkt_rep    = 1'b0;
    units_done = '0;

    // reset state: one 4-byte unit per image, coded
    add_byte(8'h80);
    add_byte(8'hff); add_byte(8'hff); add_byte(8'hff);
    add_word(8'hff, 32'hffff_ffff, 8'd1, 1'b1, 1'b0);
    // repeat run past the image end
    add_byte(8'h85);
    add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
    add_word(8'h00, 32'h0, 8'd1, 1'b1, 1'b1);
    // zero unit size and zero image size, uncoded
    add_reg(tga_rle_pkg::CFG_BYTES_PER_UNIT, 32'd0);
    add_reg(tga_rle_pkg::CFG_RLE_ENABLED, 32'd0);
    add_reg(tga_rle_pkg::CFG_TOTAL_UNITS, 32'd0);
    add_word(8'h5a, 32'h5a, 8'd1, 1'b1, 1'b0);
    // oversized unit size, longest repeat, a very large image
    add_reg(tga_rle_pkg::CFG_BYTES_PER_UNIT, 32'd7);
    add_reg(tga_rle_pkg::CFG_RLE_ENABLED, 32'd1);
    add_reg(tga_rle_pkg::CFG_TOTAL_UNITS, 32'hfffe_0001);
    add_byte(8'hff);
    add_byte(8'h01); add_byte(8'h02); add_byte(8'h03);
    add_word(8'h04, 32'h0403_0201, 8'd128, 1'b0, 1'b0);
    // raw packet past the image end, 3-byte units
    add_reg(tga_rle_pkg::CFG_BYTES_PER_UNIT, 32'd3);
    add_reg(tga_rle_pkg::CFG_TOTAL_UNITS, 32'd130);
    add_byte(8'h02);
    add_byte(8'h11); add_byte(8'h22); add_byte(8'h33);
    add_byte(8'h44); add_byte(8'h55); add_byte(8'h66);
    // image size lowered below the units already written
    add_reg(tga_rle_pkg::CFG_BYTES_PER_UNIT, 32'd1);
    add_reg(tga_rle_pkg::CFG_TOTAL_UNITS, 32'd10);
    add_byte(8'h81); add_byte(8'h77);
    add_reg(tga_rle_pkg::CFG_TOTAL_UNITS, 32'd1);
    add_byte(8'h02);
    add_word(8'h88, 32'h88, 8'd1, 1'b1, 1'b1);
    // unit size shrunk with a unit half assembled
    add_reg(tga_rle_pkg::CFG_BYTES_PER_UNIT, 32'd4);
    add_reg(tga_rle_pkg::CFG_TOTAL_UNITS, 32'd5);
    add_byte(8'h80); add_byte(8'hc3); add_byte(8'h3c);
    add_reg(tga_rle_pkg::CFG_BYTES_PER_UNIT, 32'd2);
    add_byte(8'h99);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_reg) begin
        settle_decoder();
        write_reg(row.idx, row.val);
      end else begin
        send_byte(row.val[7:0], row.typed, row.res);
      end
    end

    target = sent + RandomBytes;
    while (sent < target) begin
      settle_decoder();
      wrote = 1'b0;
      if ($urandom_range(1)) begin
        write_reg(tga_rle_pkg::CFG_BYTES_PER_UNIT,
                  ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(7));
        wrote = 1'b1;
      end
      if ($urandom_range(1)) begin
        write_reg(tga_rle_pkg::CFG_RLE_ENABLED,
                  ($urandom_range(9) < 8) ? 32'd1 : 32'd0);
        wrote = 1'b1;
      end
      if (!wrote || $urandom_range(1)) begin
        write_reg(tga_rle_pkg::CFG_TOTAL_UNITS, rand_total());
      end

      for (int p = 0; p < $urandom_range(3, 12) && sent < target; p++) begin
        if (!hold_done && sent > 300) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        n = unit_bytes();
        if (!cfg_rle) begin
          repeat ($urandom_range(1, 12)) send_byte(rand_byte(), 1'b0, '0);
        end else begin
          kind = $urandom_range(9);
          len  = ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(7);
          if (kind == 0) begin
            send_byte(rand_byte(), 1'b0, '0);
          end else if (kind <= 3) begin
            send_byte(tga_rle_pkg::RunFlagMask | (8'(len) & tga_rle_pkg::RunLenMask),
                      1'b0, '0);
            repeat (n) send_byte(rand_byte(), 1'b0, '0);
          end else begin
            units = len + 1;
            // truncated raw packet
            if (kind == 9) units = $urandom_range(units);
            send_byte(8'(len) & tga_rle_pkg::RunLenMask, 1'b0, '0);
            repeat (units * n) send_byte(rand_byte(), 1'b0, '0);
          end
        end
      end
    end

    settle_decoder();
    if (errors == 0) begin
      $display("tb_tga_rle_pixel_decoder_unit passed");
    end else begin
      $display("tb_tga_rle_pixel_decoder_unit failed");
    end
    $finish;
  end

endmodule
